// ----- rtl/ray_box_slab_intersect_macros.svh -----
// Assertion macros used by the checker.
`ifndef RAY_BOX_SLAB_INTERSECT_MACROS_SVH
`define RAY_BOX_SLAB_INTERSECT_MACROS_SVH

// Checked at every edge outside reset.
`define RBSI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define RBSI_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/rbsi_pkg.sv -----
package rbsi_pkg;

  localparam int FRAC_BITS = 16;
  localparam int QW        = 32;          // quotient bits, one per divider stage
  localparam int NLANE     = 6;           // two plane distances per axis
  localparam int NAXIS     = 3;
  localparam int NSTG      = QW + 2;      // front, divider steps, slab resolve

  localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] ONE   = 32'sh1 <<< FRAC_BITS;

  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] nlo;
    logic [31:0] ad;
    logic [31:0] q;
    logic        neg;
    logic        ovf;
  } lane_t;

  typedef struct packed {
    logic zero;
    logic in_slab;
  } axis_t;

  typedef struct packed {
    lane_t [NLANE-1:0] lane;
    axis_t [NAXIS-1:0] axis;
  } div_t;

  typedef struct packed {
    logic        hit;
    logic [30:0] distance;
  } res_t;

endpackage

// ----- rtl/rbsi_ray_if.sv -----
interface rbsi_ray_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] origin_x;
  logic signed [31:0] origin_y;
  logic signed [31:0] origin_z;
  logic signed [31:0] dir_x;
  logic signed [31:0] dir_y;
  logic signed [31:0] dir_z;

  modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  input ready);
  modport sink   (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  output ready);
endinterface

// ----- rtl/rbsi_res_if.sv -----
interface rbsi_res_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [30:0] distance;

  modport source (output valid, hit, distance, input ready);
  modport sink   (input valid, hit, distance, output ready);
endinterface

// ----- rtl/ray_box_slab_intersect.sv -----
// Ray versus unit cube [-1,1]^3, slab method.
// A ray passes the front stage, 32 divider steps, slab resolve and output
// buffer. Throughput: one ray per cycle unless the buffer is full and the
// sink stalls; the six radix-2 divider lanes set the depth.
// Reset (rst, synchronous) clears all valid bits and the output buffer.
module ray_box_slab_intersect
  import rbsi_pkg::*;
(
  input  logic clk,
  input  logic rst,
  rbsi_ray_if.sink   ray,
  rbsi_res_if.source res
);

  // Whole pipe shifts together; the two-entry output buffer absorbs
  // the in-flight result when the sink stalls, so rays keep flowing
  // while one result waits.
  logic            adv;
  logic [NSTG-1:0] v;
  logic            full;

  logic signed [31:0] o [NAXIS];
  logic signed [31:0] d [NAXIS];

  div_t front_q;
  div_t div_q;
  res_t res_c;
  res_t res_q;

  assign adv       = !full || res.ready;
  assign ray.ready = adv;

  assign o[0] = ray.origin_x;
  assign o[1] = ray.origin_y;
  assign o[2] = ray.origin_z;
  assign d[0] = ray.dir_x;
  assign d[1] = ray.dir_y;
  assign d[2] = ray.dir_z;

  // valid bits ride alongside the payload stages
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[NSTG-2:0], ray.valid};
    end
  end

  // stage 0: numerators, magnitudes, overflow, zero-direction and in-slab flags
  rbsi_front u_front (
    .clk  (clk),
    .adv  (adv),
    .o    (o),
    .d    (d),
    .dout (front_q)
  );

  // stages 1..32: one quotient bit per stage, six lanes
  rbsi_div_pipe u_div (
    .clk  (clk),
    .adv  (adv),
    .din  (front_q),
    .dout (div_q)
  );

  // stage 33: saturate, order entry/exit; then hit decision
  rbsi_resolve u_resolve (
    .clk (clk),
    .adv (adv),
    .din (div_q),
    .res (res_c)
  );

  rbsi_out_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (adv && v[NSTG-1]),
    .din   (res_c),
    .pop   (res.valid && res.ready),
    .valid (res.valid),
    .full  (full),
    .dout  (res_q)
  );

  assign res.hit      = res_q.hit;
  assign res.distance = res_q.distance;

endmodule

// ----- rtl/rbsi_front.sv -----
module rbsi_front
  import rbsi_pkg::*;
(
  input  logic               clk,
  input  logic               adv,
  input  logic signed [31:0] o [NAXIS],
  input  logic signed [31:0] d [NAXIS],
  output div_t               dout
);

  div_t nxt;

  always_comb begin
    logic signed [32:0] one33;
    logic signed [32:0] num;
    logic [31:0]        an;
    logic [31:0]        ad;
    logic [63:0]        nfull;
    int                 a;
    one33 = 33'(ONE);
    nxt   = '0;
    for (int l = 0; l < NLANE; l++) begin
      a   = l / 2;
      num = (l % 2 == 1) ? one33 - 33'(o[a]) : -one33 - 33'(o[a]);
      an  = num[32] ? 32'(-num) : num[31:0];
      ad  = d[a][31] ? 32'(-d[a]) : d[a];
      // numerator magnitude shifted into fixed point
      nfull = 64'(an) << FRAC_BITS;
      nxt.lane[l].ovf = nfull >= {ad, 32'b0};
      nxt.lane[l].neg = num[32] ^ d[a][31];
      nxt.lane[l].ad  = ad;
      nxt.lane[l].rem = nfull[63:32];
      nxt.lane[l].nlo = nfull[31:0];
      nxt.lane[l].q   = '0;
    end
    for (int x = 0; x < NAXIS; x++) begin
      nxt.axis[x].zero    = d[x] == 32'sd0;
      nxt.axis[x].in_slab = (o[x] >= -ONE) && (o[x] <= ONE);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dout <= nxt;
    end
  end

endmodule

// ----- rtl/rbsi_div_pipe.sv -----
module rbsi_div_pipe
  import rbsi_pkg::*;
(
  input  logic clk,
  input  logic adv,
  input  div_t din,
  output div_t dout
);

  div_t st [QW];

  // one restoring step: one quotient bit
  function automatic lane_t lane_step(lane_t x);
    logic [32:0] t;
    logic        ge;
    lane_t       y;
    y     = x;
    t     = {x.rem, x.nlo[31]};
    ge    = t >= {1'b0, x.ad};
    y.rem = ge ? 32'(t - {1'b0, x.ad}) : t[31:0];
    y.q   = {x.q[30:0], ge};
    y.nlo = {x.nlo[30:0], 1'b0};
    return y;
  endfunction

  for (genvar s = 0; s < QW; s++) begin : g_step
    div_t src;
    div_t nxt;
    assign src = (s == 0) ? din : st[(s == 0) ? 0 : s - 1];
    always_comb begin
      nxt = src;
      for (int l = 0; l < NLANE; l++) begin
        nxt.lane[l] = lane_step(src.lane[l]);
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        st[s] <= nxt;
      end
    end
  end

  assign dout = st[QW-1];

endmodule

// ----- rtl/rbsi_resolve.sv -----
module rbsi_resolve
  import rbsi_pkg::*;
(
  input  logic clk,
  input  logic adv,
  input  div_t din,
  output res_t res
);

  logic signed [31:0] tin      [NAXIS];
  logic signed [31:0] tout     [NAXIS];
  logic signed [31:0] tin_next [NAXIS];
  logic signed [31:0] tout_next[NAXIS];
  logic               miss;
  logic               miss_next;

  function automatic logic signed [31:0] sat(lane_t x);
    if (x.ovf) return x.neg ? Q_MIN : Q_MAX;
    if (x.neg) return x.q[31] ? Q_MIN : -$signed(x.q);
    return x.q[31] ? Q_MAX : $signed(x.q);
  endfunction

  always_comb begin
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    miss_next = 1'b0;
    for (int x = 0; x < NAXIS; x++) begin
      lo = sat(din.lane[2*x]);
      hi = sat(din.lane[2*x+1]);
      if (din.axis[x].zero) begin
        tin_next[x]  = Q_MIN;
        tout_next[x] = Q_MAX;
        if (!din.axis[x].in_slab) miss_next = 1'b1;
      end else if (lo > hi) begin
        tin_next[x]  = hi;
        tout_next[x] = lo;
      end else begin
        tin_next[x]  = lo;
        tout_next[x] = hi;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tin  <= tin_next;
      tout <= tout_next;
      miss <= miss_next;
    end
  end

  // latest entry, earliest exit
  always_comb begin
    logic signed [31:0] tmin;
    logic signed [31:0] tmax;
    tmin = tin[0];
    tmax = tout[0];
    for (int x = 1; x < NAXIS; x++) begin
      if (tin[x] > tmin)  tmin = tin[x];
      if (tout[x] < tmax) tmax = tout[x];
    end
    res = '0;
    if (!miss && tmin <= tmax) begin
      if (tmin > 32'sd0) begin
        res.hit      = 1'b1;
        res.distance = tmin[30:0];
      end else if (tmax > 32'sd0) begin
        res.hit      = 1'b1;
        res.distance = tmax[30:0];
      end
    end
  end

endmodule

// ----- rtl/rbsi_out_fifo.sv -----
module rbsi_out_fifo
  import rbsi_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  res_t din,
  input  logic pop,
  output logic valid,
  output logic full,
  output res_t dout
);

  res_t       mem [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;

  assign valid = cnt != 2'd0;
  assign full  = cnt == 2'd2;
  assign dout  = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop)  rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= din;
    end
  end

endmodule

// ----- rtl/rbsi_chk.sv -----
`include "ray_box_slab_intersect_macros.svh"

module rbsi_chk (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        hit,
  input logic [30:0] distance
);

  `RBSI_ASSERT(a_miss_zero, out_valid && !hit |-> distance == 31'd0, "miss with nonzero distance")
  `RBSI_ASSERT(a_hold, out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(distance), "stalled result changed")
  `RBSI_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "result valid after reset")
  `RBSI_ASSERT(a_ready_when_empty, !out_valid |-> in_ready, "input stalled with empty output")

endmodule

bind ray_box_slab_intersect rbsi_chk u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (ray.ready),
  .out_valid (res.valid),
  .out_ready (res.ready),
  .hit       (res.hit),
  .distance  (res.distance)
);
